// ===== design/string_literal_escape_decoder_top_assert.svh =====
// Assertion macros shared by the string literal escape decoder modules.
`ifndef STRING_LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_LITERAL_ESCAPE_DECODER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SLED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SLED_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sled_pkg.sv =====
// Types, constants and encoding functions of the string literal escape decoder.
`timescale 1ns / 1ps

package sled_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NUM_STEPS   = 12;

    // Step positions inside a queued request
    localparam int STEP_PRE  = 0;
    localparam int STEP_BSL  = 1;
    localparam int STEP_REP0 = 2;
    localparam int STEP_TAIL = 10;
    localparam int STEP_FIN  = 11;

    localparam logic [1:0] ENC_UTF8  = 2'd0;
    localparam logic [1:0] ENC_UTF16 = 2'd1;
    localparam logic [1:0] ENC_UTF32 = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NEWLINE = 2'd1;
    localparam logic [1:0] ST_EMPTY_X = 2'd2;
    localparam logic [1:0] ST_NOT_LIT = 2'd3;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       token_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] unit;
        logic [1:0]  encoding;
        logic        is_end;
        logic [1:0]  status;
        logic        is_char_constant;
        logic [15:0] unit_count;
    } out_item_t;

    // One request from front to back: the steps to run, in bit order
    typedef struct packed {
        logic [NUM_STEPS-1:0] mask;
        logic [31:0]          pre_cp;
        logic [1:0]           pre_st;
        logic [7:0][7:0]      rep;
        logic [7:0]           tail;
        logic [1:0]           enc;
        logic                 sq;
        logic [1:0]           fin_st;
        logic [15:0]          count;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = c[3:0];
        if (c >= "0" && c <= "9")
            h.val = c[3:0];
        else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            h.val = 4'(c[3:0] + 4'd9);
        else
            h.ok = 1'b0;
        return h;
    endfunction

    function automatic logic [31:0] clamp_cp(input logic [31:0] cp, input logic [1:0] enc);
        return (enc != ENC_UTF32 && cp > 32'h10FFFF) ? 32'hFFFD : cp;
    endfunction

    // Number of code units for one code point
    function automatic logic [2:0] unit_len(input logic [31:0] cp_in, input logic [1:0] enc);
        logic [31:0] cp;
        cp = clamp_cp(cp_in, enc);
        if (enc == ENC_UTF32)
            return 3'd1;
        else if (enc == ENC_UTF16)
            return (cp < 32'h10000) ? 3'd1 : 3'd2;
        else if (cp < 32'h80)
            return 3'd1;
        else if (cp < 32'h800)
            return 3'd2;
        else if (cp < 32'h10000)
            return 3'd3;
        else
            return 3'd4;
    endfunction

    // Code unit k of one code point
    function automatic logic [31:0] enc_unit(input logic [31:0] cp_in, input logic [1:0] enc,
                                             input logic [1:0] k);
        logic [31:0] cp;
        logic [19:0] v;
        logic [2:0]  n;
        logic [2:0]  pos;
        logic [5:0]  six;
        cp  = clamp_cp(cp_in, enc);
        v   = 20'(cp - 32'h10000);
        n   = unit_len(cp_in, enc);
        pos = 3'(n - 3'd1 - 3'(k));
        six = 6'(cp >> (6 * pos));
        if (enc == ENC_UTF32)
            return cp;
        else if (enc == ENC_UTF16)
        begin
            if (n == 3'd1)
                return cp;
            else if (k == 2'd0)
                return 32'hD800 + 32'(v[19:10]);
            else
                return 32'hDC00 + 32'(v[9:0]);
        end
        else if (n == 3'd1)
            return cp;
        else if (k != 2'd0)
            return 32'h80 | 32'(six);
        else if (n == 3'd2)
            return 32'hC0 | 32'(cp[10:6]);
        else if (n == 3'd3)
            return 32'hE0 | 32'(cp[15:12]);
        else
            return 32'hF0 | 32'(cp[20:18]);
    endfunction

endpackage

// ===== design/sled_front.sv =====
// Front part: prefix and escape parsing, one source byte per cycle while accept is high.
`timescale 1ns / 1ps

module sled_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  sled_pkg::in_item_t src,
    output logic              q_wr,
    output sled_pkg::req_t    q_data
);

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_AFTER_U = 8'b0000_0010,
        PH_WANT_Q  = 8'b0000_0100,
        PH_BODY    = 8'b0000_1000,
        PH_ESC     = 8'b0001_0000,
        PH_OCTAL   = 8'b0010_0000,
        PH_HEX     = 8'b0100_0000,
        PH_UNI     = 8'b1000_0000
    } phase_t;

    localparam int CW = sled_pkg::COUNT_WIDTH;

    phase_t           ph_reg, ph_next;
    logic [1:0]       enc_reg, enc_next;
    logic             sq_reg, sq_next;
    logic [31:0]      val_reg, val_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [CW-1:0]    units_reg, units_next;
    logic [7:0][7:0]  rep_reg, rep_next;

    logic [7:0]       c;
    sled_pkg::hex_t   hv;
    sled_pkg::req_t   e;
    logic             do_body;
    logic             not_lit;
    logic [CW-1:0]    base;
    logic [4:0]       inc;
    logic [CW:0]      sum;
    logic [3:0]       cnt_inc;
    logic [31:0]      val_shift;

    always_comb
    begin
        c         = src.src_byte;
        hv        = sled_pkg::hex_val(c);
        ph_next   = ph_reg;
        enc_next  = enc_reg;
        sq_next   = sq_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        rep_next  = rep_reg;
        base      = units_reg;
        e         = '0;
        do_body   = 1'b0;
        not_lit   = 1'b0;
        cnt_inc   = 4'(cnt_reg + 4'd1);
        val_shift = {val_reg[27:0], hv.val};

        if (accept)
        begin
            if (src.token_start)
            begin
                enc_next = sled_pkg::ENC_UTF8;
                sq_next  = 1'b0;
                val_next = '0;
                cnt_next = '0;
                base     = '0;
                if (c == "u")
                begin
                    enc_next = sled_pkg::ENC_UTF16;
                    ph_next  = PH_AFTER_U;
                end
                else if (c == "U" || c == "L")
                begin
                    enc_next = sled_pkg::ENC_UTF32;
                    ph_next  = PH_WANT_Q;
                end
                else if (c == sled_pkg::CH_SQUOTE || c == sled_pkg::CH_DQUOTE)
                begin
                    sq_next = (c == sled_pkg::CH_SQUOTE);
                    ph_next = PH_BODY;
                end
                else
                begin
                    not_lit = 1'b1;
                end
            end
            else
            begin
                unique case (ph_reg)
                    PH_IDLE:
                    begin
                        ph_next = PH_IDLE;
                    end
                    PH_AFTER_U:
                    begin
                        if (c == "8")
                        begin
                            enc_next = sled_pkg::ENC_UTF8;
                            ph_next  = PH_WANT_Q;
                        end
                        else if (c == sled_pkg::CH_SQUOTE || c == sled_pkg::CH_DQUOTE)
                        begin
                            sq_next = (c == sled_pkg::CH_SQUOTE);
                            ph_next = PH_BODY;
                        end
                        else
                        begin
                            not_lit = 1'b1;
                        end
                    end
                    PH_WANT_Q:
                    begin
                        if (c == sled_pkg::CH_SQUOTE || c == sled_pkg::CH_DQUOTE)
                        begin
                            sq_next = (c == sled_pkg::CH_SQUOTE);
                            ph_next = PH_BODY;
                        end
                        else
                        begin
                            not_lit = 1'b1;
                        end
                    end
                    PH_BODY:
                    begin
                        do_body = 1'b1;
                    end
                    PH_ESC:
                    begin
                        if (c >= "0" && c <= "7")
                        begin
                            val_next = 32'(c[2:0]);
                            cnt_next = 4'd1;
                            ph_next  = PH_OCTAL;
                        end
                        else if (c == "x")
                        begin
                            val_next = '0;
                            cnt_next = '0;
                            ph_next  = PH_HEX;
                        end
                        else if (c == "u" || c == "U")
                        begin
                            rep_next[0] = c;
                            val_next    = '0;
                            cnt_next    = '0;
                            ph_next     = PH_UNI;
                        end
                        else
                        begin
                            ph_next = PH_BODY;
                            e.mask[sled_pkg::STEP_PRE] = 1'b1;
                            unique case (c)
                                "a":     e.pre_cp = 32'(sled_pkg::CH_BEL);
                                "b":     e.pre_cp = 32'(sled_pkg::CH_BS);
                                "f":     e.pre_cp = 32'(sled_pkg::CH_FF);
                                "n":     e.pre_cp = 32'(sled_pkg::CH_NL);
                                "r":     e.pre_cp = 32'(sled_pkg::CH_CR);
                                "t":     e.pre_cp = 32'(sled_pkg::CH_TAB);
                                "v":     e.pre_cp = 32'(sled_pkg::CH_VT);
                                default: e.pre_cp = 32'(c);
                            endcase
                        end
                    end
                    PH_OCTAL:
                    begin
                        if (c >= "0" && c <= "7")
                        begin
                            val_next = {val_reg[28:0], c[2:0]};
                            cnt_next = cnt_inc;
                            if (cnt_inc >= 4'd3)
                            begin
                                ph_next  = PH_BODY;
                                e.mask[sled_pkg::STEP_PRE] = 1'b1;
                                e.pre_cp = val_next;
                            end
                        end
                        else
                        begin
                            e.mask[sled_pkg::STEP_PRE] = 1'b1;
                            e.pre_cp = val_reg;
                            do_body  = 1'b1;
                        end
                    end
                    PH_HEX:
                    begin
                        if (hv.ok)
                        begin
                            val_next = val_shift;
                            if (cnt_reg != 4'd15)
                                cnt_next = cnt_inc;
                        end
                        else
                        begin
                            e.mask[sled_pkg::STEP_PRE] = 1'b1;
                            if (cnt_reg == 4'd0)
                            begin
                                e.pre_cp = '0;
                                e.pre_st = sled_pkg::ST_EMPTY_X;
                            end
                            else
                            begin
                                e.pre_cp = val_reg;
                            end
                            do_body = 1'b1;
                        end
                    end
                    PH_UNI:
                    begin
                        if (hv.ok)
                        begin
                            val_next = val_shift;
                            if (cnt_reg < 4'd7)
                                rep_next[3'(cnt_reg[2:0] + 3'd1)] = c;
                            cnt_next = cnt_inc;
                            if (cnt_inc >= ((rep_reg[0] == "U") ? 4'd8 : 4'd4))
                            begin
                                ph_next  = PH_BODY;
                                e.mask[sled_pkg::STEP_PRE] = 1'b1;
                                e.pre_cp = val_shift;
                            end
                        end
                        else
                        begin
                            // replay backslash and the held characters
                            e.mask[sled_pkg::STEP_BSL] = 1'b1;
                            for (int i = 0; i < 8; i++)
                                e.mask[sled_pkg::STEP_REP0 + i] = (4'(i) <= cnt_reg);
                            do_body = 1'b1;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_IDLE;
                    end
                endcase
            end
        end

        if (do_body)
        begin
            ph_next = PH_BODY;
            if (c == sled_pkg::CH_NL)
            begin
                e.mask[sled_pkg::STEP_FIN] = 1'b1;
                e.fin_st = sled_pkg::ST_NEWLINE;
                ph_next  = PH_IDLE;
            end
            else if (c == (sq_reg ? sled_pkg::CH_SQUOTE : sled_pkg::CH_DQUOTE))
            begin
                e.mask[sled_pkg::STEP_FIN] = 1'b1;
                e.fin_st = sled_pkg::ST_OK;
                ph_next  = PH_IDLE;
            end
            else if (c == sled_pkg::CH_BSLASH)
            begin
                ph_next = PH_ESC;
            end
            else
            begin
                e.mask[sled_pkg::STEP_TAIL] = 1'b1;
                e.tail = c;
            end
        end

        if (not_lit)
        begin
            e.mask[sled_pkg::STEP_FIN] = 1'b1;
            e.fin_st = sled_pkg::ST_NOT_LIT;
            ph_next  = PH_IDLE;
        end

        e.rep = rep_next;

        // count the units this request will produce
        inc = '0;
        if (e.mask[sled_pkg::STEP_PRE])
            inc = 5'(inc + 5'(sled_pkg::unit_len(e.pre_cp, enc_next)));
        if (e.mask[sled_pkg::STEP_BSL])
            inc = 5'(inc + 5'd1 + 5'($countones(e.mask[sled_pkg::STEP_REP0 +: 8])));
        if (e.mask[sled_pkg::STEP_TAIL])
            inc = 5'(inc + 5'(sled_pkg::unit_len(32'(e.tail), enc_next)));
        sum        = (CW + 1)'(base) + (CW + 1)'(inc);
        units_next = sum[CW] ? '1 : sum[CW-1:0];

        e.enc   = not_lit ? sled_pkg::ENC_UTF8 : enc_next;
        e.sq    = not_lit ? 1'b0 : sq_next;
        e.count = not_lit ? 16'd0 :
                  ((33'(units_next) > 33'(16'hFFFF)) ? 16'hFFFF : 16'(units_next));

        q_data = e;
        q_wr   = accept && (e.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= PH_IDLE;
            enc_reg   <= '0;
            sq_reg    <= 1'b0;
            val_reg   <= '0;
            cnt_reg   <= '0;
            units_reg <= '0;
        end
        else
        begin
            ph_reg    <= ph_next;
            enc_reg   <= enc_next;
            sq_reg    <= sq_next;
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            units_reg <= units_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
    end

endmodule

// ===== design/sled_queue.sv =====
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

`include "string_literal_escape_decoder_top_assert.svh"

module sled_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  sled_pkg::req_t  wr_data,
    input  logic            rd,
    output sled_pkg::req_t  rd_data,
    output logic            full,
    output logic            nonempty
);

    localparam int PW = sled_pkg::QPTR_W;

    sled_pkg::req_t mem_reg [sled_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [PW:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW + 1)'(sled_pkg::QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr ? PW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = rd ? PW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = (PW + 1)'(cnt_reg + (PW + 1)'(wr) - (PW + 1)'(rd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    `SLED_ASSERT(a_no_overflow, !(wr && full && !rd), "request written into a full queue")
    `SLED_ASSERT(a_no_underflow, !(rd && !nonempty), "request read from an empty queue")
    `SLED_ASSERT_ALWAYS(a_count_bound, cnt_reg <= (PW + 1)'(sled_pkg::QUEUE_DEPTH),
        "queue fill count out of range")

endmodule

// ===== design/sled_back.sv =====
// Back part: expands queued requests into code units and end items, one per cycle while results are popped.
`timescale 1ns / 1ps

`include "string_literal_escape_decoder_top_assert.svh"

module sled_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sled_pkg::req_t     q_data,
    input  logic               q_nonempty,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output sled_pkg::out_item_t result
);

    localparam int NS = sled_pkg::NUM_STEPS;

    logic                busy_reg, busy_next;
    sled_pkg::req_t      ent_reg, ent_next;
    logic [NS-1:0]       mask_reg, mask_next;
    logic [1:0]          k_reg, k_next;
    logic                ov_reg, ov_next;
    sled_pkg::out_item_t out_reg, out_next;

    logic [NS-1:0] cur;
    logic [NS-1:0] mask_after;
    logic [31:0]   cp;
    logic [2:0]    n;
    logic          is_fin;
    logic          step_done;
    logic          can_adv;
    logic          emit;
    logic          load;

    always_comb
    begin
        can_adv    = !ov_reg || pop;
        cur        = mask_reg & NS'(~mask_reg + 1'b1);
        mask_after = mask_reg & ~cur;
        is_fin     = cur[sled_pkg::STEP_FIN];

        // lowest pending step gives the code point
        cp = 32'(ent_reg.tail);
        for (int i = 7; i >= 0; i--)
        begin
            if (mask_reg[sled_pkg::STEP_REP0 + i])
                cp = 32'(ent_reg.rep[i]);
        end
        if (mask_reg[sled_pkg::STEP_BSL])
            cp = 32'(sled_pkg::CH_BSLASH);
        if (mask_reg[sled_pkg::STEP_PRE])
            cp = ent_reg.pre_cp;

        n         = sled_pkg::unit_len(cp, ent_reg.enc);
        step_done = is_fin || (3'(k_reg) == 3'(n - 3'd1));
        emit      = busy_reg && can_adv;

        busy_next = busy_reg;
        ent_next  = ent_reg;
        mask_next = mask_reg;
        k_next    = k_reg;
        ov_next   = (ov_reg && !pop);
        out_next  = out_reg;

        if (emit)
        begin
            ov_next                   = 1'b1;
            out_next.unit             = is_fin ? 32'd0 : sled_pkg::enc_unit(cp, ent_reg.enc, k_reg);
            out_next.encoding         = ent_reg.enc;
            out_next.is_end           = is_fin;
            out_next.status           = is_fin ? ent_reg.fin_st :
                                        (cur[sled_pkg::STEP_PRE] ? ent_reg.pre_st
                                                                 : sled_pkg::ST_OK);
            out_next.is_char_constant = ent_reg.sq;
            out_next.unit_count       = is_fin ? ent_reg.count : 16'd0;
            if (step_done)
            begin
                mask_next = mask_after;
                k_next    = '0;
            end
            else
            begin
                k_next = 2'(k_reg + 2'd1);
            end
        end

        load = !busy_reg || (emit && step_done && (mask_after == '0));
        q_rd = load && q_nonempty;
        if (load)
        begin
            busy_next = q_nonempty;
            ent_next  = q_data;
            mask_next = q_data.mask;
            k_next    = '0;
        end
    end

    assign empty  = !ov_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
            k_reg    <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            mask_reg <= mask_next;
            k_reg    <= k_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    `SLED_ASSERT(a_busy_has_steps, busy_reg |-> (mask_reg != '0), "busy with no pending step")
    `SLED_ASSERT(a_held_on_stall, (ov_reg && !pop) |=> $stable(out_reg),
        "waiting result changed before it was taken")

endmodule

// ===== design/string_literal_escape_decoder_top.sv =====
// Top level of the C string literal escape decoder.
// Takes one source byte per cycle (push/full) and delivers code units and end items
// in order (empty/pop). The front parser handles one byte per cycle unless full; each
// byte turns into zero to eleven result items, and the back expander delivers one item per
// cycle while results are popped, so input stalls when the four-entry request queue fills,
// as bytes yield more than one item or results wait. While results are popped, the rate is
// one byte per cycle if each byte gives at most one result, else one result per cycle.
`timescale 1ns / 1ps

module string_literal_escape_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sled_pkg::in_item_t  src,
    output logic                empty,
    input  logic                pop,
    output sled_pkg::out_item_t result
);

    logic           q_wr;
    logic           q_rd;
    logic           q_nonempty;
    sled_pkg::req_t q_wdata;
    sled_pkg::req_t q_rdata;

    sled_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push && !full),
        .src    (src),
        .q_wr   (q_wr),
        .q_data (q_wdata)
    );

    sled_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_data  (q_wdata),
        .rd       (q_rd),
        .rd_data  (q_rdata),
        .full     (full),
        .nonempty (q_nonempty)
    );

    sled_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rdata),
        .q_nonempty (q_nonempty),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule
